### design/ple_pkg.sv
// Shared types and constants for the positional list engine.
// Holds the request and result formats, the operation codes and the list size.
package ple_pkg;

    localparam int CAPACITY = 32;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int MODE_W   = 3;
    localparam int POS_W    = 6;
    localparam int DATA_W   = 32;
    localparam int COUNT_W  = 6;
    // wide enough for count + 1 and position compares
    localparam int EXT_W    = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

    localparam logic [MODE_W-1:0] MODE_INSERT = 3'd0;
    localparam logic [MODE_W-1:0] MODE_DELETE = 3'd1;
    localparam logic [MODE_W-1:0] MODE_READ   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_LOCATE = 3'd3;
    localparam logic [MODE_W-1:0] MODE_PRED   = 3'd4;
    localparam logic [MODE_W-1:0] MODE_SUCC   = 3'd5;
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd6;

    typedef struct packed {
        logic [MODE_W-1:0]        mode;
        logic [POS_W-1:0]         position;
        logic signed [DATA_W-1:0] item_value;
    } t_in_item;

    typedef struct packed {
        logic                     status;
        logic signed [DATA_W-1:0] result_value;
        logic [POS_W-1:0]         found_position;
        logic [COUNT_W-1:0]       count;
    } t_out_item;

    typedef struct packed {
        logic capture;   // latch request, compare all cells
        logic execute;   // apply operation, load result register
    } t_dp_cmd;

endpackage

### design/ple_datapath.sv
// Datapath of the positional list engine: the cell chain, the parallel
// compare, the request latch and the result register. Uses ple_pkg.
module ple_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ple_pkg::t_dp_cmd    i_cmd,
    input  ple_pkg::t_in_item   i_in_data,
    output ple_pkg::t_out_item  o_out_data
);

    logic [ple_pkg::DATA_W-1:0]   r_cell [ple_pkg::CAPACITY];
    logic [ple_pkg::DATA_W-1:0]   n_cell [ple_pkg::CAPACITY];
    logic [ple_pkg::CAPACITY-1:0] r_match, n_match;
    logic [ple_pkg::CNT_W-1:0]    r_count, n_count;
    ple_pkg::t_in_item            r_req;
    ple_pkg::t_out_item           r_out, n_out;

    logic [ple_pkg::CNT_W-1:0]    hit;
    logic [ple_pkg::EXT_W-1:0]    pos_x, cnt_x, hit_x, rd_x;
    logic [ple_pkg::IDX_W-1:0]    rd_idx, wr_idx;
    logic [ple_pkg::DATA_W-1:0]   rd_data;
    logic                         ins_ok, pos_ok, do_ins, do_del;

    // compare against every live cell when the request comes in
    always_comb begin
        for (int k = 0; k < ple_pkg::CAPACITY; k++) begin
            n_match[k] = (r_cell[k] == i_in_data.item_value)
                         && (ple_pkg::CNT_W'(k) < r_count);
        end
    end

    // lowest matching cell wins
    always_comb begin
        hit = '0;
        for (int k = ple_pkg::CAPACITY - 1; k >= 0; k--) begin
            if (r_match[k]) begin
                hit = ple_pkg::CNT_W'(k + 1);
            end
        end
    end

    always_comb begin
        pos_x  = ple_pkg::EXT_W'(r_req.position);
        cnt_x  = ple_pkg::EXT_W'(r_count);
        hit_x  = ple_pkg::EXT_W'(hit);
        ins_ok = (pos_x >= ple_pkg::EXT_W'(1)) && (pos_x <= cnt_x + ple_pkg::EXT_W'(1))
                 && (cnt_x < ple_pkg::EXT_W'(ple_pkg::CAPACITY));
        pos_ok = (pos_x >= ple_pkg::EXT_W'(1)) && (pos_x <= cnt_x);
        wr_idx = ple_pkg::IDX_W'(pos_x - ple_pkg::EXT_W'(1));

        case (r_req.mode)
            ple_pkg::MODE_PRED: rd_x = hit_x - ple_pkg::EXT_W'(2);
            ple_pkg::MODE_SUCC: rd_x = hit_x;
            default:            rd_x = pos_x - ple_pkg::EXT_W'(1);
        endcase
        rd_idx  = ple_pkg::IDX_W'(rd_x);
        rd_data = r_cell[rd_idx];
    end

    always_comb begin
        n_out         = '0;
        n_count       = r_count;
        n_out.status  = 1'b1;
        do_ins        = 1'b0;
        do_del        = 1'b0;
        case (r_req.mode)
            ple_pkg::MODE_INSERT: begin
                if (ins_ok) begin
                    do_ins       = 1'b1;
                    n_count      = r_count + ple_pkg::CNT_W'(1);
                    n_out.status = 1'b0;
                end
            end
            ple_pkg::MODE_DELETE: begin
                if (pos_ok) begin
                    do_del             = 1'b1;
                    n_count            = r_count - ple_pkg::CNT_W'(1);
                    n_out.result_value = rd_data;
                    n_out.status       = 1'b0;
                end
            end
            ple_pkg::MODE_READ: begin
                if (pos_ok) begin
                    n_out.result_value = rd_data;
                    n_out.status       = 1'b0;
                end
            end
            ple_pkg::MODE_LOCATE: begin
                n_out.found_position = ple_pkg::POS_W'(hit);
                n_out.status         = (hit == '0);
            end
            ple_pkg::MODE_PRED: begin
                if (hit_x >= ple_pkg::EXT_W'(2)) begin
                    n_out.result_value = rd_data;
                    n_out.status       = 1'b0;
                end
            end
            ple_pkg::MODE_SUCC: begin
                if ((hit != '0) && (hit_x < cnt_x)) begin
                    n_out.result_value = rd_data;
                    n_out.status       = 1'b0;
                end
            end
            ple_pkg::MODE_CLEAR: begin
                n_count      = '0;
                n_out.status = 1'b0;
            end
            default: begin
                n_out.status = 1'b1;
            end
        endcase
        n_out.count = ple_pkg::COUNT_W'(n_count);
    end

    // shift network: each cell takes its neighbor below or above
    always_comb begin
        for (int k = 0; k < ple_pkg::CAPACITY; k++) begin
            n_cell[k] = r_cell[k];
            if (do_ins) begin
                if (ple_pkg::IDX_W'(k) == wr_idx) begin
                    n_cell[k] = r_req.item_value;
                end else if ((k > 0) && (ple_pkg::IDX_W'(k) > wr_idx)) begin
                    n_cell[k] = r_cell[(k > 0) ? k - 1 : 0];
                end
            end else if (do_del) begin
                if ((k < ple_pkg::CAPACITY - 1) && (ple_pkg::IDX_W'(k) >= wr_idx)) begin
                    n_cell[k] = r_cell[(k < ple_pkg::CAPACITY - 1) ? k + 1 : k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.execute) begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req   <= i_in_data;
            r_match <= n_match;
        end
        if (i_cmd.execute) begin
            r_out  <= n_out;
            r_cell <= n_cell;
        end
    end

    assign o_out_data = r_out;

endmodule

### design/ple_control.sv
// Controller of the positional list engine: request sequencing and the
// input and output handshakes. Uses ple_pkg for the command type.
module ple_control (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output ple_pkg::t_dp_cmd o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state       = r_state;
        o_cmd.capture = 1'b0;
        o_cmd.execute = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_EXEC;
                end
            end
            ST_EXEC: begin
                // result register must be empty or draining this cycle
                if (out_free) begin
                    o_cmd.execute = 1'b1;
                    n_state       = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        n_out_valid = o_cmd.execute ? 1'b1 : (r_out_valid && i_out_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

### design/positional_list_engine.sv
// Top level of the positional list engine.
// Instantiates ple_control and ple_datapath; types come from ple_pkg.
//
// Ordered list of up to 32 signed 32-bit values, addressed by 1-based
// position. Each request transaction on the input channel (mode, position,
// item_value) yields exactly one result transaction (status, result_value,
// found_position, count) on the output channel.
// Both channels use valid/stall; a transaction moves on a clock edge where
// valid is high and stall is low.
// A request accepted at a clock edge is compared against all cells at
// that edge; the operation and shift are applied in the execute step, once
// the output register is free, and the result is presented from then on.
// A new request is not taken before the previous one has gone through the
// two-step sequence of parallel compare then shift/read. The next request is
// taken while the previous result still waits in the output register.
// When the receiver stalls with a result pending, the request after it is
// accepted but held in the execute step until the output register frees.
// Reset (synchronous, active low) empties the list and drops any pending
// result; cell contents are not cleared and are never read unless written.
module positional_list_engine (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  ple_pkg::t_in_item   i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output ple_pkg::t_out_item  o_out_data
);

    ple_pkg::t_dp_cmd cmd;

    ple_control u_control (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd)
    );

    ple_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_in_data  (i_in_data),
        .o_out_data (o_out_data)
    );

endmodule

### design/ple_checker.sv
// Port-level checks for the positional list engine, bound to the top level.
// Depends on ple_pkg for the transaction types and list capacity.
module ple_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input ple_pkg::t_in_item  i_in_data,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input ple_pkg::t_out_item o_out_data
);

    // a stalled request keeps its payload until taken
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_stall |=> i_in_valid && $stable(i_in_data))
        else $error("request changed while stalled");

    // a pending result is not withdrawn under stall
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    // one request in flight: input stalls right after a transaction
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second request taken while one is in flight");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.count <= ple_pkg::COUNT_W'(ple_pkg::CAPACITY)))
        else $error("count above capacity");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status
            |-> (o_out_data.result_value == '0) && (o_out_data.found_position == '0))
        else $error("error result carries data");

endmodule

bind positional_list_engine ple_checker u_ple_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

### dv/tb_positional_list_engine.sv
// Self-checking testbench for positional_list_engine: directed corner requests, then random
// fill/drain traffic, with random valid and stall gaps in two of its three phases, checked against
// a behavioral list model. Depends on ple_pkg (transaction structs, mode codes, CAPACITY) and the design sources.
module tb_positional_list_engine;
    timeunit 1ns;
    timeprecision 1ps;

    import ple_pkg::*;

    // Behavioral copy of the list plus the queue of results still owed by the DUT.
    class list_tracker;
        logic signed [DATA_W-1:0] cells [CAPACITY];
        int                       count;
        t_out_item                owed [$];
        int                       errors;

        function new();
            count  = 0;
            errors = 0;
        endfunction

        function int pending();
            return owed.size();
        endfunction

        // 1-based position of the first cell equal to v, 0 if none
        function int first_hit(logic signed [DATA_W-1:0] v);
            for (int k = 0; k < count; k++) begin
                if (cells[k] == v) return k + 1;
            end
            return 0;
        endfunction

        function t_out_item apply_request(t_in_item rq);
            t_out_item r;
            int        p;
            int        hit;
            r        = '0;
            r.status = 1'b1;
            p        = rq.position;
            case (rq.mode)
                MODE_INSERT: begin
                    if (p >= 1 && p <= count + 1 && count < CAPACITY) begin
                        for (int k = count; k >= p; k--) cells[k] = cells[k-1];
                        cells[p-1] = rq.item_value;
                        count++;
                        r.status = 1'b0;
                    end
                end
                MODE_DELETE: begin
                    if (p >= 1 && p <= count) begin
                        r.result_value = cells[p-1];
                        for (int k = p; k < count; k++) cells[k-1] = cells[k];
                        count--;
                        r.status = 1'b0;
                    end
                end
                MODE_READ: begin
                    if (p >= 1 && p <= count) begin
                        r.result_value = cells[p-1];
                        r.status       = 1'b0;
                    end
                end
                MODE_LOCATE: begin
                    hit              = first_hit(rq.item_value);
                    r.found_position = hit[POS_W-1:0];
                    r.status         = (hit == 0);
                end
                MODE_PRED: begin
                    hit = first_hit(rq.item_value);
                    if (hit >= 2) begin
                        r.result_value = cells[hit-2];
                        r.status       = 1'b0;
                    end
                end
                MODE_SUCC: begin
                    hit = first_hit(rq.item_value);
                    if (hit >= 1 && hit < count) begin
                        r.result_value = cells[hit];
                        r.status       = 1'b0;
                    end
                end
                MODE_CLEAR: begin
                    count    = 0;
                    r.status = 1'b0;
                end
                default: ;
            endcase
            r.count = count[COUNT_W-1:0];
            return r;
        endfunction

        function void flag_error(string msg);
            errors++;
            if (errors <= 10) $display("ERROR @%0t: %s", $realtime, msg);
        endfunction

        function void note_request(t_in_item rq);
            owed.push_back(apply_request(rq));
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (owed.size() == 0) begin
                flag_error($sformatf("result with nothing outstanding: st=%0b val=%0d pos=%0d cnt=%0d",
                    got.status, got.result_value, got.found_position, got.count));
                return;
            end
            want = owed.pop_front();
            if (got.status !== want.status || got.result_value !== want.result_value ||
                got.found_position !== want.found_position || got.count !== want.count) begin
                flag_error($sformatf(
                    "exp st=%0b val=%0d pos=%0d cnt=%0d, got st=%0b val=%0d pos=%0d cnt=%0d",
                    want.status, want.result_value, want.found_position, want.count,
                    got.status, got.result_value, got.found_position, got.count));
            end
        endfunction
    endclass

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_item  in_data   = '0;
    logic      out_stall = 1'b0;
    logic      in_stall;
    logic      out_valid;
    t_out_item out_data;

    int idle_pct  = 34;
    int stall_pct = 66;

    list_tracker sb;    // checks DUT results
    list_tracker plan;  // tracks list state for stimulus generation only

    logic signed [DATA_W-1:0] value_pool [8] = '{
        32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0, -32'sd1,
        32'sd1, 32'sd5, 32'sh5555_5555, 32'shAAAA_AAAA
    };

    positional_list_engine DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    initial begin
        forever #6 clk = ~clk;
    end

    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // Results are checked before requests are noted: a result never belongs to a
    // request accepted at the same edge.
    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && !out_stall) sb.check_result(out_data);
            if (in_valid && !in_stall) sb.note_request(in_data);
        end
    end

    function automatic t_in_item mk(logic [MODE_W-1:0] m, int p, logic signed [DATA_W-1:0] v);
        t_in_item rq;
        rq.mode       = m;
        rq.position   = p[POS_W-1:0];
        rq.item_value = v;
        return rq;
    endfunction

    function automatic t_in_item make_request(bit fill);
        t_in_item rq;
        int       w;
        int       ins;
        int       del;
        int       n;
        w   = $urandom_range(0, 99);
        ins = fill ? 60 : 22;
        del = fill ? 8 : 40;
        n   = plan.count;
        if (w < ins)                 rq.mode = MODE_INSERT;
        else if (w < ins + del)      rq.mode = MODE_DELETE;
        else if (w < ins + del + 8)  rq.mode = MODE_READ;
        else if (w < ins + del + 16) rq.mode = MODE_LOCATE;
        else if (w < ins + del + 23) rq.mode = MODE_PRED;
        else if (w < ins + del + 30) rq.mode = MODE_SUCC;
        else if (!fill && w < ins + del + 32) rq.mode = MODE_CLEAR;
        else                         rq.mode = MODE_W'($urandom_range(0, 7));
        if ($urandom_range(0, 9) < 8) begin
            if (rq.mode == MODE_INSERT)
                rq.position = POS_W'($urandom_range(1, n + 1));
            else
                rq.position = (n > 0) ? POS_W'($urandom_range(1, n)) : POS_W'(1);
        end else begin
            rq.position = POS_W'($urandom_range(0, 63));
        end
        if ($urandom_range(0, 9) < 7) rq.item_value = value_pool[$urandom_range(0, 7)];
        else                          rq.item_value = $urandom;
        return rq;
    endfunction

    task automatic send_request(t_in_item rq);
        void'(plan.apply_request(rq));
        while ($urandom_range(0, 99) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= rq;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    // hold the input channel idle until the DUT owes nothing
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
    endtask

    initial begin
        sb   = new();
        plan = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty-list errors
        send_request(mk(MODE_READ,   1, 0));
        send_request(mk(MODE_DELETE, 1, 0));
        send_request(mk(MODE_LOCATE, 0, 0));
        send_request(mk(MODE_PRED,   0, 0));
        send_request(mk(MODE_SUCC,   0, 0));
        // bad insert positions, then extremes
        send_request(mk(MODE_INSERT, 0, 7));
        send_request(mk(MODE_INSERT, 2, 7));
        send_request(mk(MODE_INSERT, 1, 32'sh8000_0000));
        send_request(mk(MODE_INSERT, 2, 32'sh7FFF_FFFF));
        send_request(mk(MODE_INSERT, 1, 0));
        send_request(mk(MODE_INSERT, 63, -1));
        send_request(mk(MODE_READ,   1, 0));
        send_request(mk(MODE_READ,   3, 0));
        send_request(mk(MODE_READ,   4, 0));
        send_request(mk(MODE_LOCATE, 0, 32'sh7FFF_FFFF));
        send_request(mk(MODE_LOCATE, 0, 12345));
        // neighbors: first has no predecessor, last has no successor
        send_request(mk(MODE_PRED,   0, 0));
        send_request(mk(MODE_PRED,   0, 32'sh8000_0000));
        send_request(mk(MODE_SUCC,   0, 32'sh7FFF_FFFF));
        send_request(mk(MODE_SUCC,   0, 0));
        send_request(mk(MODE_DELETE, 2, 0));
        send_request(mk(MODE_DELETE, 3, 0));
        send_request(mk(3'd7,       63, 32'shFFFF_FFFF));
        send_request(mk(MODE_CLEAR,  0, 0));

        for (int ph = 0; ph < 3; ph++) begin
            if (ph == 1) begin
                idle_pct  = 66;
                stall_pct = 34;
            end else if (ph == 2) begin
                idle_pct  = 0;
                stall_pct = 0;
            end
            for (int i = 0; i < 284; i++) begin
                send_request(make_request(((i / 100) % 2) == 0));
            end
            if (ph < 2) drain_results();
        end

        drain_results();
        repeat (4) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("tb_positional_list_engine OK");
        end else begin
            $display("tb_positional_list_engine NOT OK");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("tb_positional_list_engine NOT OK");
        $finish;
    end

endmodule

### filelist.f
design/ple_pkg.sv
design/ple_datapath.sv
design/ple_control.sv
design/positional_list_engine.sv
design/ple_checker.sv
dv/tb_positional_list_engine.sv
